@@ hdl/stdc_pkg.sv @@
// Package for the settable time-of-day clock: beat types, configuration
// register indexes, reset values and field codes. No dependencies.
package stdc_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TICK      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLDOFF   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOW_THR   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_THR  = 3'd4;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd200;
  localparam logic [15:0] TICK_RESET     = 16'd1000;
  localparam logic [15:0] HOLDOFF_RESET  = 16'd300;
  localparam logic [11:0] LOW_THR_RESET  = 12'd500;
  localparam logic [11:0] HIGH_THR_RESET = 12'd3500;

  localparam logic [4:0] HOUR_RESET   = 5'd14;
  localparam logic [5:0] MINUTE_RESET = 6'd30;
  localparam logic [4:0] HOUR_MAX     = 5'd23;
  localparam logic [5:0] MINUTE_MAX   = 6'd59;
  localparam logic [5:0] SECOND_MAX   = 6'd59;

  localparam logic FIELD_HOUR   = 1'b0;
  localparam logic FIELD_MINUTE = 1'b1;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [11:0] joy_x;
    logic [11:0] joy_y;
    logic        button_pressed;
  } poll_beat_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       edit_active;
    logic       edit_field;
    logic       return_to_menu;
  } result_beat_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] tick_period_ms;
    logic [15:0] exit_holdoff_ms;
    logic [11:0] low_threshold;
    logic [11:0] high_threshold;
  } cfg_regs_t;

endpackage

@@ hdl/stdc_cfg.sv @@
// Configuration register file for the settable time-of-day clock.
// Depends on stdc_pkg.
module stdc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [stdc_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [stdc_pkg::CFG_DATA_W-1:0]  wr_data,
  output stdc_pkg::cfg_regs_t              regs
);
  import stdc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.debounce_ms     <= DEBOUNCE_RESET;
      regs.tick_period_ms  <= TICK_RESET;
      regs.exit_holdoff_ms <= HOLDOFF_RESET;
      regs.low_threshold   <= LOW_THR_RESET;
      regs.high_threshold  <= HIGH_THR_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_DEBOUNCE: regs.debounce_ms     <= wr_data;
        CFG_TICK:     regs.tick_period_ms  <= wr_data;
        CFG_HOLDOFF:  regs.exit_holdoff_ms <= wr_data;
        CFG_LOW_THR:  regs.low_threshold   <= wr_data[11:0];
        CFG_HIGH_THR: regs.high_threshold  <= wr_data[11:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/stdc_core.sv @@
// Clock state and per-poll update logic: tick carry, edit mode actions.
// Depends on stdc_pkg.
module stdc_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  stdc_pkg::poll_beat_t   poll,
  input  stdc_pkg::cfg_regs_t    regs,
  output stdc_pkg::result_beat_t result
);
  import stdc_pkg::*;

  logic [4:0]  hour_count, hour_count_next;
  logic [5:0]  minute_count, minute_count_next;
  logic [5:0]  second_count, second_count_next;
  logic [31:0] last_tick_time, last_tick_time_next;
  logic [31:0] last_action_time, last_action_time_next;
  logic        editing_flag, editing_flag_next;
  logic        field_select, field_select_next;
  logic        exit_req;

  logic [31:0] since_tick, since_action;
  logic        tick, debounce_ok, holdoff_ok;
  logic        x_low, x_high, y_low, y_high;
  logic [4:0]  hour_tick;
  logic [5:0]  minute_tick, second_tick;
  logic [4:0]  hour_up, hour_down;
  logic [5:0]  minute_up, minute_down;

  assign since_tick   = poll.now_ms - last_tick_time;
  assign since_action = poll.now_ms - last_action_time;
  assign tick         = !editing_flag && (since_tick > {16'd0, regs.tick_period_ms});
  assign debounce_ok  = since_action > {16'd0, regs.debounce_ms};
  assign holdoff_ok   = since_action > {16'd0, regs.exit_holdoff_ms};
  assign x_low  = poll.joy_x < regs.low_threshold;
  assign x_high = poll.joy_x > regs.high_threshold;
  assign y_low  = poll.joy_y < regs.low_threshold;
  assign y_high = poll.joy_y > regs.high_threshold;

  assign hour_up     = (hour_count >= HOUR_MAX) ? 5'd0 : hour_count + 5'd1;
  assign hour_down   = (hour_count == 5'd0) ? HOUR_MAX : hour_count - 5'd1;
  assign minute_up   = (minute_count >= MINUTE_MAX) ? 6'd0 : minute_count + 6'd1;
  assign minute_down = (minute_count == 6'd0) ? MINUTE_MAX : minute_count - 6'd1;

  always_comb begin
    hour_tick   = hour_count;
    minute_tick = minute_count;
    second_tick = second_count;
    if (tick) begin
      if (second_count >= SECOND_MAX) begin
        second_tick = 6'd0;
        if (minute_count >= MINUTE_MAX) begin
          minute_tick = 6'd0;
          hour_tick   = hour_up;
        end else begin
          minute_tick = minute_count + 6'd1;
        end
      end else begin
        second_tick = second_count + 6'd1;
      end
    end
  end

  always_comb begin
    hour_count_next       = hour_tick;
    minute_count_next     = minute_tick;
    second_count_next     = second_tick;
    last_tick_time_next   = tick ? poll.now_ms : last_tick_time;
    last_action_time_next = last_action_time;
    editing_flag_next     = editing_flag;
    field_select_next     = field_select;
    exit_req              = 1'b0;
    if (!editing_flag) begin
      if (poll.button_pressed && debounce_ok) begin
        editing_flag_next     = 1'b1;
        field_select_next     = FIELD_HOUR;
        last_action_time_next = poll.now_ms;
      end else if (x_low && holdoff_ok) begin
        exit_req              = 1'b1;
        last_action_time_next = poll.now_ms;
      end
    end else if (debounce_ok) begin
      last_action_time_next = poll.now_ms;
      if (x_low || x_high) begin
        field_select_next = ~field_select;
      end else if (y_low) begin
        if (field_select == FIELD_HOUR) hour_count_next = hour_up;
        else minute_count_next = minute_up;
      end else if (y_high) begin
        if (field_select == FIELD_HOUR) hour_count_next = hour_down;
        else minute_count_next = minute_down;
      end else if (poll.button_pressed) begin
        editing_flag_next = 1'b0;
        second_count_next = 6'd0;
      end else begin
        last_action_time_next = last_action_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_count       <= HOUR_RESET;
      minute_count     <= MINUTE_RESET;
      second_count     <= 6'd0;
      last_tick_time   <= 32'd0;
      last_action_time <= 32'd0;
      editing_flag     <= 1'b0;
      field_select     <= FIELD_HOUR;
    end else if (advance) begin
      hour_count       <= hour_count_next;
      minute_count     <= minute_count_next;
      second_count     <= second_count_next;
      last_tick_time   <= last_tick_time_next;
      last_action_time <= last_action_time_next;
      editing_flag     <= editing_flag_next;
      field_select     <= field_select_next;
    end
  end

  assign result.hours          = hour_count_next;
  assign result.minutes        = minute_count_next;
  assign result.seconds        = second_count_next;
  assign result.edit_active    = editing_flag_next;
  assign result.edit_field     = field_select_next;
  assign result.return_to_menu = exit_req;

endmodule

@@ hdl/settable_time_of_day_clock_top.sv @@
// Each accepted poll beat passes the input register, then the result register.
// Throughput: one poll per cycle unless stalled; the input register drains into the
// result register when that register is empty or its beat is taken in the same cycle.
// Reset (rst, synchronous): clock 14:30:00, not editing, hour field, timestamps 0,
// registers to their defaults; both beat registers empty.
module settable_time_of_day_clock_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             poll_valid,
  output logic                             poll_ready,
  input  stdc_pkg::poll_beat_t             poll,
  output logic                             result_valid,
  input  logic                             result_ready,
  output stdc_pkg::result_beat_t           result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [stdc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [stdc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import stdc_pkg::*;

  logic         pipe_valid;
  poll_beat_t   pipe_beat;
  logic         advance;
  cfg_regs_t    regs;
  result_beat_t core_result;

  assign cfg_ready  = 1'b1;
  assign advance    = pipe_valid && (!result_valid || result_ready);
  assign poll_ready = !pipe_valid || advance;

  stdc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (regs)
  );

  stdc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .poll    (pipe_beat),
    .regs    (regs),
    .result  (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (poll_ready) pipe_valid <= poll_valid;
      if (advance) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
    if (poll_valid && poll_ready) pipe_beat <= poll;
    if (advance) result <= core_result;
  end

  a_hours_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.hours <= HOUR_MAX)
    else $error("hours out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.minutes <= MINUTE_MAX && result.seconds <= SECOND_MAX))
    else $error("minutes or seconds out of range");

  a_exit_not_editing: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.return_to_menu) |-> !result.edit_active)
    else $error("menu exit while editing");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !poll_ready |-> (pipe_valid && result_valid && !result_ready))
    else $error("poll stalled without backpressure");

  a_drain_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("advanced beat not presented");

endmodule
